@@ rtl/npc_pkg.sv @@
// Package: shared types and codes for the nearest palette color core.
`default_nettype none

package npc_pkg;

    localparam int CHAN_W  = 8;
    localparam int INDEX_W = 10;
    localparam int DIST_W  = 18;
    localparam int LIMIT_W = 6;
    localparam int COUNT_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT     = 2'd1;

    localparam logic [COUNT_W-1:0] ENTRIES_RESET = 11'd1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 6'd25;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] entry_index;
        logic [CHAN_W-1:0]  query_red;
        logic [CHAN_W-1:0]  query_green;
        logic [CHAN_W-1:0]  query_blue;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] color_index;
        logic               exact_match;
        logic [CHAN_W-1:0]  chosen_red;
        logic [CHAN_W-1:0]  chosen_green;
        logic [CHAN_W-1:0]  chosen_blue;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/npc_palette_ram.sv @@
// Palette storage: one write port, one registered read port.
`default_nettype none

module npc_palette_ram
    import npc_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire rgb_t              wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output rgb_t                   rdata
);

    rgb_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/nearest_palette_color_core.sv @@
// Nearest palette color core: palette load, exact and nearest color search.
// A write request gives no result; busy stays low.
// A query scans n = entries in use (clamped to 1..PALETTE_DEPTH) entries, one palette
// read per cycle; busy stays high until the finish state has given the result or swallowed a miss.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset clears control and the miss counter and sets the register defaults; palette and data registers stay undefined.
`default_nettype none

module nearest_palette_color_core
    import npc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire req_t                 req,
    output logic                      result_valid,
    output rsp_t                      result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COUNT_W-1:0]   cfg_data
);

    localparam int IW = $clog2(PALETTE_DEPTH);

    typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] entries_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] miss_reg;

    rgb_t               q_reg;
    logic [IW-1:0]      last_reg;
    logic [IW-1:0]      rd_addr_reg;
    logic               issue_reg;

    logic               v1_reg;
    logic [IW-1:0]      idx1_reg;
    rgb_t               rdata;

    logic               v2_reg;
    logic [IW-1:0]      idx2_reg;
    rgb_t               col2_reg;
    logic [DIST_W-1:0]  dist2_reg;
    logic               exact2_reg;

    logic               found_reg;
    logic [IW-1:0]      hit_idx_reg;
    rgb_t               hit_col_reg;
    logic [IW-1:0]      best_idx_reg;
    rgb_t               best_col_reg;
    logic [DIST_W-1:0]  best_dist_reg;

    logic               accept;
    logic               ram_we;
    rgb_t               req_color;
    logic [IW-1:0]      last_next;
    logic [DIST_W-1:0]  dist_next;

    assign busy      = (state_reg != IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign req_color = '{red: req.query_red, green: req.query_green, blue: req.query_blue};
    assign ram_we    = accept && (req.op == OP_WRITE)
                       && (32'(req.entry_index) < 32'(PALETTE_DEPTH));

    // Clamp entries in use to 1..depth and take the last index scanned
    always_comb
    begin
        if (entries_reg == '0)
        begin
            last_next = '0;
        end
        else if (32'(entries_reg) > 32'(PALETTE_DEPTH))
        begin
            last_next = IW'(PALETTE_DEPTH - 1);
        end
        else
        begin
            last_next = IW'(entries_reg - 11'd1);
        end
    end

    function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    assign dist_next = DIST_W'(sq_diff(rdata.red,   q_reg.red))
                     + DIST_W'(sq_diff(rdata.green, q_reg.green))
                     + DIST_W'(sq_diff(rdata.blue,  q_reg.blue));

    npc_palette_ram #(
        .DEPTH  (PALETTE_DEPTH),
        .ADDR_W (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IW'(req.entry_index)),
        .wdata (req_color),
        .re    (issue_reg),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            entries_reg  <= ENTRIES_RESET;
            limit_reg    <= LIMIT_RESET;
            miss_reg     <= '0;
            issue_reg    <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            found_reg    <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ENTRIES_IN_USE: entries_reg <= cfg_data;
                    CFG_MISS_LIMIT:     limit_reg   <= cfg_data[LIMIT_W-1:0];
                    default:            ;
                endcase
            end

            // Read issue: one address per cycle up to the last entry in use
            if (issue_reg)
            begin
                if (rd_addr_reg == last_reg)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    rd_addr_reg <= rd_addr_reg + IW'(1);
                end
            end
            v1_reg   <= issue_reg;
            idx1_reg <= rd_addr_reg;

            // Distance stage
            v2_reg     <= v1_reg;
            idx2_reg   <= idx1_reg;
            col2_reg   <= rdata;
            dist2_reg  <= dist_next;
            exact2_reg <= (rdata == q_reg);

            // Compare stage: keep first exact hit and first least distance
            if (v2_reg)
            begin
                if (exact2_reg && !found_reg)
                begin
                    found_reg   <= 1'b1;
                    hit_idx_reg <= idx2_reg;
                    hit_col_reg <= col2_reg;
                end
                if ((idx2_reg == '0) || (dist2_reg < best_dist_reg))
                begin
                    best_dist_reg <= dist2_reg;
                    best_idx_reg  <= idx2_reg;
                    best_col_reg  <= col2_reg;
                end
            end

            unique case (state_reg)
                IDLE:
                begin
                    if (accept && (req.op == OP_QUERY))
                    begin
                        q_reg       <= req_color;
                        last_reg    <= last_next;
                        rd_addr_reg <= '0;
                        issue_reg   <= 1'b1;
                        found_reg   <= 1'b0;
                        state_reg   <= SCAN;
                    end
                end
                SCAN:
                begin
                    if (v2_reg && (idx2_reg == last_reg))
                    begin
                        state_reg <= FINISH;
                    end
                end
                FINISH:
                begin
                    state_reg <= IDLE;
                    if (found_reg)
                    begin
                        result_valid       <= 1'b1;
                        result.color_index <= INDEX_W'(hit_idx_reg);
                        result.exact_match <= 1'b1;
                        result.chosen_red   <= hit_col_reg.red;
                        result.chosen_green <= hit_col_reg.green;
                        result.chosen_blue  <= hit_col_reg.blue;
                    end
                    else if (miss_reg <= limit_reg)
                    begin
                        // swallow this miss
                        miss_reg <= miss_reg + LIMIT_W'(1);
                    end
                    else
                    begin
                        miss_reg           <= '0;
                        result_valid       <= 1'b1;
                        result.color_index <= INDEX_W'(best_idx_reg);
                        result.exact_match <= 1'b0;
                        result.chosen_red   <= best_col_reg.red;
                        result.chosen_green <= best_col_reg.green;
                        result.chosen_blue  <= best_col_reg.blue;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ bench/npc_checker.sv @@
`timescale 1ns / 1ps
// Checker for the nearest palette color core: predicts each request and compares results.
module npc_checker
    import npc_pkg::*;
#(
    parameter int PALETTE_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire req_t                 req,
    input  wire logic                 result_valid,
    input  wire rsp_t                 result,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COUNT_W-1:0]   cfg_data,
    output int                        errors,
    output int                        outstanding,
    output int                        compared
);

    rgb_t               pal_mem [PALETTE_DEPTH];
    logic [LIMIT_W-1:0] miss_run;
    logic [COUNT_W-1:0] reg_entries;
    logic [LIMIT_W-1:0] reg_limit;
    rsp_t               expected_colors [$];
    int                 err_count = 0;
    int                 pending_count = 0;
    int                 match_count = 0;

    assign errors      = err_count;
    assign outstanding = pending_count;
    assign compared    = match_count;

    function automatic int color_distance(rgb_t a, rgb_t b);
        int dr;
        int dg;
        int db;
        dr = int'(a.red) - int'(b.red);
        dg = int'(a.green) - int'(b.green);
        db = int'(a.blue) - int'(b.blue);
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic rsp_t pack_choice(int idx, logic exact);
        rsp_t r;
        r.color_index  = idx[INDEX_W-1:0];
        r.exact_match  = exact;
        r.chosen_red   = pal_mem[idx].red;
        r.chosen_green = pal_mem[idx].green;
        r.chosen_blue  = pal_mem[idx].blue;
        return r;
    endfunction

    // Append a predicted result behind those already waiting.
    task automatic note_expected(rsp_t r);
        expected_colors = {expected_colors, r};
    endtask

    // Store a palette write, or work out what a color query returns, if anything.
    task automatic predict_color_request(req_t q);
        rgb_t want;
        int   span;
        int   best;
        int   best_dist;
        int   d;
        want = {q.query_red, q.query_green, q.query_blue};
        if (q.op == OP_WRITE) begin
            if (int'(q.entry_index) < PALETTE_DEPTH)
                pal_mem[q.entry_index] = want;
            return;
        end
        span = int'(reg_entries);
        if (span == 0)
            span = 1;
        if (span > PALETTE_DEPTH)
            span = PALETTE_DEPTH;
        for (int i = 0; i < span; i++) begin
            if (pal_mem[i] == want) begin
                note_expected(pack_choice(i, 1'b1));
                return;
            end
        end
        // swallow the miss while the counter has not passed the limit; 6-bit wrap
        if (miss_run <= reg_limit) begin
            miss_run = miss_run + LIMIT_W'(1);
            return;
        end
        miss_run  = '0;
        best      = 0;
        best_dist = color_distance(pal_mem[0], want);
        for (int i = 1; i < span; i++) begin
            d = color_distance(pal_mem[i], want);
            if (d < best_dist) begin
                best_dist = d;
                best      = i;
            end
        end
        note_expected(pack_choice(best, 1'b0));
    endtask

    task automatic check_field(string name, logic [INDEX_W-1:0] want, logic [INDEX_W-1:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            miss_run    = '0;
            reg_entries = ENTRIES_RESET;
            reg_limit   = LIMIT_RESET;
            expected_colors.delete();
            pending_count = 0;
        end
        else begin
            if (result_valid === 1'b1) begin
                if (expected_colors.size() == 0) begin
                    err_count++;
                    $display("%0t ns: unexpected result, expected none, actual %p", $time, result);
                end
                else begin
                    want = expected_colors.pop_front();
                    match_count++;
                    check_field("color_index", want.color_index, result.color_index);
                    check_field("exact_match", INDEX_W'(want.exact_match),
                                INDEX_W'(result.exact_match));
                    check_field("chosen_red", INDEX_W'(want.chosen_red),
                                INDEX_W'(result.chosen_red));
                    check_field("chosen_green", INDEX_W'(want.chosen_green),
                                INDEX_W'(result.chosen_green));
                    check_field("chosen_blue", INDEX_W'(want.chosen_blue),
                                INDEX_W'(result.chosen_blue));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ENTRIES_IN_USE: reg_entries = cfg_data;
                    CFG_MISS_LIMIT:     reg_limit   = cfg_data[LIMIT_W-1:0];
                    default:            ;
                endcase
            end
            if (start && !busy)
                predict_color_request(req);
            pending_count = expected_colors.size();
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the bench: clock, reset, palette and query stimulus, register writes and the verdict.
module testbench;
    import npc_pkg::*;

    localparam int PALETTE_DEPTH = 1024;
    localparam int CLK_HALF      = 5;
    localparam int RUN_LIMIT_NS  = 20_000_000;

    // register slots with nothing behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct {
        logic [COUNT_W-1:0] entries;
        logic [LIMIT_W-1:0] limit;
        int                 count;
        int                 idle_pct;
    } phase_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    req_t                 req       = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data  = '0;
    logic                 busy;
    logic                 result_valid;
    rsp_t                 result;
    logic                 cfg_ready;
    int                   errors;
    int                   outstanding;
    int                   compared;

    rgb_t   shade  [PALETTE_DEPTH];
    bit     loaded [PALETTE_DEPTH];
    phase_t plan   [10];
    int     span          = PALETTE_DEPTH;
    int     idle_pct      = 0;
    int     requests_sent = 0;
    int     queries_sent  = 0;
    int     settings_used = 0;

    nearest_palette_color_core #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    npc_checker #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .outstanding  (outstanding),
        .compared     (compared)
    );

    always #CLK_HALF clk = ~clk;

    initial begin
        #RUN_LIMIT_NS;
        $display("%0t ns: run timed out", $time);
        $display("Regression FAIL");
        $finish;
    end

    function automatic int clamp_span(logic [COUNT_W-1:0] e);
        if (e == 0)
            return 1;
        if (int'(e) > PALETTE_DEPTH)
            return PALETTE_DEPTH;
        return int'(e);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic rgb_t random_color();
        return {pick_chan(), pick_chan(), pick_chan()};
    endfunction

    function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[CHAN_W-1:0];
    endfunction

    // Hold the request until accepted, then maybe drop start for a burst.
    task automatic send(req_t item);
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        if (item.op == OP_QUERY)
            queries_sent++;
        else begin
            shade[item.entry_index]  = {item.query_red, item.query_green, item.query_blue};
            loaded[item.entry_index] = 1'b1;
        end
        if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic write_entry(int idx, rgb_t c);
        req_t item;
        item.op          = OP_WRITE;
        item.entry_index = idx[INDEX_W-1:0];
        item.query_red   = c.red;
        item.query_green = c.green;
        item.query_blue  = c.blue;
        send(item);
    endtask

    task automatic query_color(rgb_t c);
        req_t item;
        item.op          = OP_QUERY;
        item.entry_index = INDEX_W'($urandom_range(0, PALETTE_DEPTH - 1));
        item.query_red   = c.red;
        item.query_green = c.green;
        item.query_blue  = c.blue;
        send(item);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(logic [COUNT_W-1:0] entries, logic [LIMIT_W-1:0] limit);
        write_reg(CFG_ENTRIES_IN_USE, entries);
        write_reg(CFG_MISS_LIMIT, {{(COUNT_W - LIMIT_W){1'b0}}, limit});
        cfg_valid <= 1'b0;
        span = clamp_span(entries);
        settings_used++;
    endtask

    // Drain expected results, then let a search that emits nothing run out.
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (span + 8) @(posedge clk);
    endtask

    task automatic random_request();
        int   k;
        int   j;
        rgb_t c;
        if ($urandom_range(1, 100) <= 30) begin
            if ($urandom_range(0, 9) < 7)
                j = $urandom_range(0, span - 1);
            else
                j = $urandom_range(0, PALETTE_DEPTH - 1);
            // duplicates make the lowest matching index matter
            if ($urandom_range(0, 3) == 0)
                c = shade[$urandom_range(0, span - 1)];
            else
                c = random_color();
            write_entry(j, c);
        end
        else begin
            k = $urandom_range(0, 99);
            if (k < 45)
                c = shade[$urandom_range(0, span - 1)];
            else if (k < 55) begin
                j = $urandom_range(0, PALETTE_DEPTH - 1);
                c = loaded[j] ? shade[j] : random_color();
            end
            else if (k < 80) begin
                c = shade[$urandom_range(0, span - 1)];
                c = {nudge(c.red), nudge(c.green), nudge(c.blue)};
            end
            else
                c = random_color();
            query_color(c);
        end
    endtask

    initial begin
        plan[0] = '{11'd3,    6'd0,  70, 20};
        plan[1] = '{11'd16,   6'd2,  80, 40};
        plan[2] = '{11'd1,    6'd5,  30, 0};
        plan[3] = '{11'd40,   6'd0,  14, 10};
        plan[4] = '{11'd0,    6'd63, 40, 30};
        plan[5] = '{11'd64,   6'd62, 70, 20};
        plan[6] = '{11'd10,   6'd25, 60, 50};
        plan[7] = '{11'd32,   6'd1,  60, 25};
        plan[8] = '{11'd48,   6'd0,   8, 0};
        plan[9] = '{11'd12,   6'd3,  80, 0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_SPARE_LO, 11'h2AA);
        write_reg(CFG_SPARE_HI, 11'h555);
        configure(11'd4, 6'd0);

        // palette extremes, a duplicate of entry 0, and the top slot outside the search
        write_entry(0, 24'h000000);
        write_entry(1, 24'hFFFFFF);
        write_entry(2, 24'h808080);
        write_entry(3, 24'h000000);
        write_entry(PALETTE_DEPTH - 1, 24'hFF0000);
        query_color(24'h000000);
        query_color(24'hFFFFFF);
        query_color(24'h808080);
        // an exact hit between two misses leaves the miss counter alone
        query_color(24'h010101);
        query_color(24'h000000);
        query_color(24'h010101);
        // equal distance to entries 0 and 2: lowest index wins
        query_color(24'h404040);
        query_color(24'h404040);
        query_color(24'hC0C0C0);
        query_color(24'hC0C0C0);
        query_color(24'hFF0000);
        query_color(24'h00FF00);
        settle();

        // zero entries in use searches entry 0 only
        configure(11'd0, 6'd1);
        query_color(24'h808080);
        query_color(24'h808080);
        query_color(24'h000000);
        query_color(24'h808080);

        foreach (plan[p]) begin
            settle();
            configure(plan[p].entries, plan[p].limit);
            idle_pct = plan[p].idle_pct;
            for (int i = 0; i < span; i++) begin
                if (!loaded[i])
                    write_entry(i, random_color());
            end
            repeat (plan[p].count) random_request();
        end
        settle();

        $display("Sent %0d requests (%0d color queries) under %0d register settings.",
                 requests_sent, queries_sent, settings_used);
        $display("Compared %0d results, entries in use from 0 to 64, miss limit 0 to 63.",
                 compared);
        if (errors == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
